// ----- hw/rtl/tsc_pkg.sv -----
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int unsigned Letters  = 25;
  localparam int unsigned Side     = 5;
  localparam int unsigned LowSplit = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CharW    = 8;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CharW-1:0] char_t;

  localparam idx_t  CountFull = idx_t'(Letters);
  localparam idx_t  LastIdx   = idx_t'(Letters - 1);
  localparam char_t CharSpace = 8'h20;
  localparam char_t CharUpA   = 8'h41;
  localparam char_t CharUpZ   = 8'h5a;
  localparam char_t CharLoA   = 8'h61;
  localparam char_t CharLoZ   = 8'h7a;
  localparam char_t CharLoQ   = 8'h71;
  localparam char_t CaseFold  = 8'h20;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_KEY1  = 3'd1,
    MODE_KEY2  = 3'd2,
    MODE_TEXT  = 3'd3,
    MODE_FLUSH = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DISPATCH,
    ST_LOOKUP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic ok;
    idx_t idx;
  } letter_t;

  function automatic letter_t letter_index(char_t c);
    letter_t res;
    char_t   v;
    char_t   off;
    v = c;
    if (v >= CharUpA && v <= CharUpZ) begin
      v = v + CaseFold;
    end
    off = v - CharLoA;
    res.ok  = (v >= CharLoA) && (v <= CharLoZ) && (v != CharLoQ);
    res.idx = (off < char_t'(LowSplit)) ? off[IdxW-1:0] : off[IdxW-1:0] - idx_t'(1);
    return res;
  endfunction

  function automatic char_t index_to_ascii(idx_t i);
    char_t w;
    w = {{(CharW-IdxW){1'b0}}, i};
    return (i < idx_t'(LowSplit)) ? w + CharLoA : w + CharLoA + char_t'(1);
  endfunction

  function automatic idx_t cell_row(idx_t c);
    idx_t r;
    if (c >= idx_t'(4 * Side)) r = idx_t'(4);
    else if (c >= idx_t'(3 * Side)) r = idx_t'(3);
    else if (c >= idx_t'(2 * Side)) r = idx_t'(2);
    else if (c >= idx_t'(Side)) r = idx_t'(1);
    else r = idx_t'(0);
    return r;
  endfunction

  function automatic idx_t cell_col(idx_t c);
    idx_t r;
    r = cell_row(c);
    return c - idx_t'(r * Side);
  endfunction

  function automatic idx_t cell_at(idx_t r, idx_t c);
    return idx_t'(r * Side) + c;
  endfunction

endpackage

// ----- hw/rtl/tsc_ram.sv -----
`timescale 1ns / 1ps

module tsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/two_square_cipher.sv -----
`timescale 1ns / 1ps

// Horizontal two-square cipher over the 25-letter alphabet without q. Each input item carries
// a mode in s_axis_tuser and an ASCII character in s_axis_tdata. Clear and key letters are taken
// in the idle state. The first text letter or flush after key loading first completes both squares
// in a fill pass. After that a text letter passes the dispatch and lookup states and, if it closes a
// pair, the result state; a flush with a held letter passes dispatch and result, one without only
// dispatch. Lookup uses the place memory reads and the result state the square memory reads.
// Results leave through a two-entry output queue, so the next item is taken while results still
// wait; a new pair only stalls if the queue has not drained by the time its letters are read.
module two_square_cipher
  import tsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_char[7:0]
  input  logic [2:0] s_axis_tuser,   // mode[2:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char[7:0]
  output logic [0:0] m_axis_tuser,   // bad_char[0]
  output logic       m_axis_tlast
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  idx_t   idx_q, idx_d;
  logic   bad_q, bad_d;
  logic   space_q, space_d;
  idx_t   fill_q, fill_d;
  logic [Letters-1:0] used1_q, used1_d, used2_q, used2_d;
  idx_t   cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic   done_q, done_d;
  logic   pend_valid_q, pend_valid_d;
  idx_t   pend_cell_q, pend_cell_d;
  logic   pend_bad_q, pend_bad_d;
  idx_t   sq1_raddr_q, sq2_raddr_q;
  logic   q0_valid_q, q0_valid_d, q1_valid_q, q1_valid_d;
  char_t  q0_char_q, q0_char_d, q1_char_q, q1_char_d;
  logic   q0_bad_q, q0_bad_d, q1_bad_q, q1_bad_d;
  logic   q0_last_q, q0_last_d;

  logic    in_fire, pop;
  mode_e   in_mode;
  letter_t in_let;
  logic    place1_en, place2_en;
  idx_t    place1_idx, place2_idx;
  idx_t    sq1_raddr, sq2_raddr;
  idx_t    sq1_rdata, sq2_rdata, pl1_rdata, pl2_rdata;
  idx_t    cell_pos;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign in_mode       = mode_e'(s_axis_tuser);
  assign in_let        = letter_index(s_axis_tdata);
  assign pop           = m_axis_tvalid & m_axis_tready;

  assign m_axis_tvalid   = q0_valid_q;
  assign m_axis_tdata    = q0_char_q;
  assign m_axis_tuser[0] = q0_bad_q;
  assign m_axis_tlast    = q0_last_q;

  tsc_ram #(.Width(IdxW), .Depth(Letters)) u_square_one (
    .clk_i   (clk_i),
    .we_i    (place1_en),
    .waddr_i (cnt1_q),
    .wdata_i (place1_idx),
    .raddr_i (sq1_raddr),
    .rdata_o (sq1_rdata)
  );

  tsc_ram #(.Width(IdxW), .Depth(Letters)) u_square_two (
    .clk_i   (clk_i),
    .we_i    (place2_en),
    .waddr_i (cnt2_q),
    .wdata_i (place2_idx),
    .raddr_i (sq2_raddr),
    .rdata_o (sq2_rdata)
  );

  tsc_ram #(.Width(IdxW), .Depth(Letters)) u_place_one (
    .clk_i   (clk_i),
    .we_i    (place1_en),
    .waddr_i (place1_idx),
    .wdata_i (cnt1_q),
    .raddr_i (idx_q),
    .rdata_o (pl1_rdata)
  );

  tsc_ram #(.Width(IdxW), .Depth(Letters)) u_place_two (
    .clk_i   (clk_i),
    .we_i    (place2_en),
    .waddr_i (place2_idx),
    .wdata_i (cnt2_q),
    .raddr_i (idx_q),
    .rdata_o (pl2_rdata)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    bad_d        = bad_q;
    space_d      = space_q;
    fill_d       = fill_q;
    used1_d      = used1_q;
    used2_d      = used2_q;
    cnt1_d       = cnt1_q;
    cnt2_d       = cnt2_q;
    done_d       = done_q;
    pend_valid_d = pend_valid_q;
    pend_cell_d  = pend_cell_q;
    pend_bad_d   = pend_bad_q;
    q0_valid_d   = q0_valid_q;
    q0_char_d    = q0_char_q;
    q0_bad_d     = q0_bad_q;
    q0_last_d    = q0_last_q;
    q1_valid_d   = q1_valid_q;
    q1_char_d    = q1_char_q;
    q1_bad_d     = q1_bad_q;
    place1_en    = 1'b0;
    place2_en    = 1'b0;
    place1_idx   = in_let.idx;
    place2_idx   = in_let.idx;
    sq1_raddr    = sq1_raddr_q;
    sq2_raddr    = sq2_raddr_q;
    cell_pos     = bad_q ? idx_t'(0) : (pend_valid_q ? pl2_rdata : pl1_rdata);

    // advance the output queue
    if (pop) begin
      q0_valid_d = q1_valid_q;
      q0_char_d  = q1_char_q;
      q0_bad_d   = q1_bad_q;
      q0_last_d  = 1'b1;
      q1_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d  = in_mode;
          idx_d   = in_let.idx;
          bad_d   = ~in_let.ok;
          space_d = (s_axis_tdata == CharSpace);
          unique case (in_mode)
            MODE_CLEAR: begin
              used1_d      = '0;
              used2_d      = '0;
              cnt1_d       = '0;
              cnt2_d       = '0;
              done_d       = 1'b0;
              pend_valid_d = 1'b0;
              pend_cell_d  = '0;
              pend_bad_d   = 1'b0;
            end
            MODE_KEY1: begin
              place1_en = ~done_q & in_let.ok & ~used1_q[in_let.idx] & (cnt1_q < CountFull);
            end
            MODE_KEY2: begin
              place2_en = ~done_q & in_let.ok & ~used2_q[in_let.idx] & (cnt2_q < CountFull);
            end
            MODE_TEXT, MODE_FLUSH: begin
              fill_d  = '0;
              state_d = done_q ? ST_DISPATCH : ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        place1_idx = fill_q;
        place2_idx = fill_q;
        place1_en  = ~used1_q[fill_q] & (cnt1_q < CountFull);
        place2_en  = ~used2_q[fill_q] & (cnt2_q < CountFull);
        fill_d     = fill_q + idx_t'(1);
        if (fill_q == LastIdx) begin
          done_d  = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (mode_q == MODE_TEXT) begin
          state_d = space_q ? ST_IDLE : ST_LOOKUP;
        end else if (pend_valid_q) begin
          sq1_raddr = pend_cell_q;
          state_d   = ST_RESULT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_cell_d  = cell_pos;
          pend_bad_d   = bad_q;
          state_d      = ST_IDLE;
        end else begin
          sq1_raddr = cell_at(cell_row(pend_cell_q), cell_col(cell_pos));
          sq2_raddr = cell_at(cell_row(cell_pos), cell_col(pend_cell_q));
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!q0_valid_q) begin
          q0_valid_d = 1'b1;
          q0_char_d  = index_to_ascii(sq1_rdata);
          q0_bad_d   = pend_bad_q;
          if (mode_q == MODE_TEXT) begin
            q0_last_d  = 1'b0;
            q1_valid_d = 1'b1;
            q1_char_d  = index_to_ascii(sq2_rdata);
            q1_bad_d   = bad_q;
          end else begin
            q0_last_d = 1'b1;
          end
          pend_valid_d = 1'b0;
          pend_cell_d  = '0;
          pend_bad_d   = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (place1_en) begin
      used1_d[place1_idx] = 1'b1;
      cnt1_d              = cnt1_q + idx_t'(1);
    end
    if (place2_en) begin
      used2_d[place2_idx] = 1'b1;
      cnt2_d              = cnt2_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used1_q      <= '0;
      used2_q      <= '0;
      cnt1_q       <= '0;
      cnt2_q       <= '0;
      done_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_cell_q  <= '0;
      pend_bad_q   <= 1'b0;
      q0_valid_q   <= 1'b0;
      q1_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      used1_q      <= used1_d;
      used2_q      <= used2_d;
      cnt1_q       <= cnt1_d;
      cnt2_q       <= cnt2_d;
      done_q       <= done_d;
      pend_valid_q <= pend_valid_d;
      pend_cell_q  <= pend_cell_d;
      pend_bad_q   <= pend_bad_d;
      q0_valid_q   <= q0_valid_d;
      q1_valid_q   <= q1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    bad_q       <= bad_d;
    space_q     <= space_d;
    fill_q      <= fill_d;
    sq1_raddr_q <= sq1_raddr;
    sq2_raddr_q <= sq2_raddr;
    q0_char_q   <= q0_char_d;
    q0_bad_q    <= q0_bad_d;
    q0_last_q   <= q0_last_d;
    q1_char_q   <= q1_char_d;
    q1_bad_q    <= q1_bad_d;
  end

endmodule
